### rtl/lc3_instruction_execute_core_assert.svh
// ----------------------------------------------------------------------------
// LC-3 execute core assertion macros
// Concurrent assertion shorthands; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define LC3_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// expr holds at every clock edge out of reset
`define LC3IE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// ante in this cycle implies cons in the next
`define LC3IE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define LC3IE_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define LC3IE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/lc3ie_pkg.sv
// ----------------------------------------------------------------------------
// LC-3 execute core package
// Shared types, opcode and function codes, and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lc3ie_pkg;

  typedef logic [15:0] word_t;

  // register file geometry
  localparam int RF_DEPTH = 8;
  localparam int RF_AW    = 3;

  // item function codes
  localparam logic [1:0] FN_EXEC  = 2'd0;
  localparam logic [1:0] FN_WRITE = 2'd1;
  localparam logic [1:0] FN_READ  = 2'd2;

  // opcodes, instruction bits 15:12
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_RES  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  // condition codes
  localparam logic [2:0] FL_P = 3'b001;
  localparam logic [2:0] FL_Z = 3'b010;
  localparam logic [2:0] FL_N = 3'b100;

  localparam word_t      START_PC_RESET = 16'h3000;
  localparam logic [2:0] FLAGS_RESET    = FL_Z;

  // link register for JSR/JSRR
  localparam logic [RF_AW-1:0] LINK_REG = 3'd7;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_t;

  // step strobes from the sequencer to the datapath
  typedef struct packed {
    logic step_read;
    logic step_exec;
    logic commit;
  } ctrl_t;

endpackage

`default_nettype wire

### rtl/lc3ie_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle when enabled, read-first, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read data holds while the port is not enabled
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

### rtl/lc3ie_regfile.sv
// ----------------------------------------------------------------------------
// LC-3 general register file
// Two RAM copies for two read ports; valid bits make unwritten regs read 0.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_regfile (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        rd_en,
  input  wire logic [lc3ie_pkg::RF_AW-1:0] rd_addr_a,
  input  wire logic [lc3ie_pkg::RF_AW-1:0] rd_addr_b,
  input  wire logic                        wr_en,
  input  wire logic [lc3ie_pkg::RF_AW-1:0] wr_addr,
  input  wire lc3ie_pkg::word_t            wr_data,
  output lc3ie_pkg::word_t                 rd_data_a,
  output lc3ie_pkg::word_t                 rd_data_b
);

  import lc3ie_pkg::*;

  logic [RF_DEPTH-1:0] rv_r;
  logic                va_r;
  logic                vb_r;
  logic [RF_AW-1:0]    addr_a;
  logic [RF_AW-1:0]    addr_b;
  word_t               q_a;
  word_t               q_b;

  // write wins the port; reads and writes come in different steps
  assign addr_a = wr_en ? wr_addr : rd_addr_a;
  assign addr_b = wr_en ? wr_addr : rd_addr_b;

  lc3ie_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_bank_a (
    .clk   (clk),
    .en    (rd_en | wr_en),
    .we    (wr_en),
    .addr  (addr_a),
    .wdata (wr_data),
    .rdata (q_a)
  );

  lc3ie_ram #(.WIDTH(16), .DEPTH(RF_DEPTH)) u_bank_b (
    .clk   (clk),
    .en    (rd_en | wr_en),
    .we    (wr_en),
    .addr  (addr_b),
    .wdata (wr_data),
    .rdata (q_b)
  );

  // per-register written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r <= '0;
    end else if (wr_en) begin
      rv_r[wr_addr] <= 1'b1;
    end
  end

  // flags follow the read data latency
  always_ff @(posedge clk) begin
    if (rd_en) begin
      va_r <= rv_r[rd_addr_a];
      vb_r <= rv_r[rd_addr_b];
    end
  end

  assign rd_data_a = va_r ? q_a : 16'h0000;
  assign rd_data_b = vb_r ? q_b : 16'h0000;

endmodule

`default_nettype wire

### rtl/lc3ie_seq.sv
// ----------------------------------------------------------------------------
// LC-3 execute sequencer
// Steps each item through read, execute and commit; handles input stall.
// ----------------------------------------------------------------------------
`default_nettype none

module lc3ie_seq (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      out_busy,
  input  wire logic      out_stall,
  output logic           in_stall,
  output lc3ie_pkg::ctrl_t ctrl
);

  import lc3ie_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_free;

  // result register can take a new item this cycle
  assign out_free = !out_busy || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and step strobes
  always_comb begin
    state_nxt      = state_r;
    in_stall       = 1'b1;
    ctrl.step_read = 1'b0;
    ctrl.step_exec = 1'b0;
    ctrl.commit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        ctrl.step_read = 1'b1;
        state_nxt      = ST_EXEC;
      end
      ST_EXEC: begin
        ctrl.step_exec = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        // commit and take the next item in the same cycle
        if (out_free) begin
          ctrl.commit = 1'b1;
          in_stall    = 1'b0;
          state_nxt   = in_valid ? ST_READ : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/lc3_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// LC-3 instruction execute core
// Executes one LC-3 instruction, or one direct memory access, per item.
// ----------------------------------------------------------------------------
// Every item takes three steps (register/memory read, execute, commit);
// the commit step waits while a held result is stalled on the output.
// The steps are set by the single-port word memory: LDI and STI need two
// dependent accesses to it before the commit. A new item is taken
// in the commit cycle of the previous one, and a result register separates
// the output side, so a waiting result does not hold the input while it
// still has room. The word memory is not cleared: a word never written
// reads as an unknown value. Writing cfg_data loads the PC at once.
`default_nettype none

`include "lc3_instruction_execute_core_assert.svh"

module lc3_instruction_execute_core #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // item input
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_func,
  input  wire lc3ie_pkg::word_t in_instruction,
  input  wire lc3ie_pkg::word_t in_mem_address,
  input  wire lc3ie_pkg::word_t in_mem_data,
  // result output
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lc3ie_pkg::word_t      out_pc_after,
  output logic [2:0]            out_cond_codes,
  output logic [2:0]            out_dest_index,
  output lc3ie_pkg::word_t      out_dest_value,
  output logic                  out_reg_written,
  output lc3ie_pkg::word_t      out_read_data,
  output logic                  out_illegal_op,
  // start PC write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire lc3ie_pkg::word_t cfg_data
);

  import lc3ie_pkg::*;

  localparam int AW        = MEM_ADDR_BITS;
  localparam int MEM_DEPTH = 2 ** MEM_ADDR_BITS;

  function automatic logic [2:0] flags_of(input word_t v);
    if (v == 16'h0000) begin
      return FL_Z;
    end else if (v[15]) begin
      return FL_N;
    end
    return FL_P;
  endfunction

  ctrl_t ctrl;
  logic  in_accept;

  // item registers
  logic [1:0] func_r;
  word_t      ins_r;
  word_t      maddr_r;
  word_t      mdata_r;

  // architectural state
  word_t      pc_r;
  logic [2:0] flags_r;

  // execute-step results
  word_t      res_r;
  word_t      res_nxt;
  word_t      npc_r;
  word_t      npc_nxt;

  // result register
  logic       out_valid_r;
  word_t      out_pc_after_r;
  logic [2:0] out_cond_codes_r;
  logic [2:0] out_dest_index_r;
  word_t      out_dest_value_r;
  logic       out_reg_written_r;
  word_t      out_read_data_r;
  logic       out_illegal_op_r;

  // decode
  logic [3:0]       op;
  logic [RF_AW-1:0] dr;
  logic [RF_AW-1:0] sr1;
  logic [RF_AW-1:0] sr2;
  word_t            imm5;
  word_t            off6;
  word_t            off9;
  word_t            off11;
  logic             is_exec;
  logic             illegal;
  logic             is_store;

  // datapath
  word_t      pc_inc;
  word_t      tgt9;
  word_t      tgt11;
  word_t      ra;
  word_t      rb;
  word_t      opb;
  word_t      base6;
  word_t      mem_q;
  logic       mem_en;
  logic       mem_we;
  logic [AW-1:0] mem_addr;
  word_t      mem_wdata;

  // commit
  logic             wr_w;
  logic [RF_AW-1:0] didx_w;
  word_t            dval_w;
  logic [2:0]       flags_nxt;
  logic             rf_we;

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  lc3ie_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_busy  (out_valid_r),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      func_r  <= in_func;
      ins_r   <= in_instruction;
      maddr_r <= in_mem_address;
      mdata_r <= in_mem_data;
    end
  end

  // field decode
  assign op    = ins_r[15:12];
  assign dr    = ins_r[11:9];
  assign sr1   = ins_r[8:6];
  assign sr2   = ins_r[2:0];
  assign imm5  = {{11{ins_r[4]}}, ins_r[4:0]};
  assign off6  = {{10{ins_r[5]}}, ins_r[5:0]};
  assign off9  = {{7{ins_r[8]}}, ins_r[8:0]};
  assign off11 = {{5{ins_r[10]}}, ins_r[10:0]};

  assign is_exec  = (func_r == FN_EXEC);
  assign illegal  = is_exec && ((op == OP_RTI) || (op == OP_RES) || (op == OP_TRAP));
  assign is_store = (op == OP_ST) || (op == OP_STI) || (op == OP_STR);

  assign pc_inc = pc_r + 16'd1;
  assign tgt9   = pc_inc + off9;
  assign tgt11  = pc_inc + off11;

  // register file: sr1 on port A, sr2 or store source on port B
  lc3ie_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (ctrl.step_read),
    .rd_addr_a (sr1),
    .rd_addr_b (is_store ? dr : sr2),
    .wr_en     (rf_we),
    .wr_addr   (didx_w),
    .wr_data   (dval_w),
    .rd_data_a (ra),
    .rd_data_b (rb)
  );

  assign opb   = ins_r[5] ? imm5 : rb;
  assign base6 = ra + off6;

  // word memory port: one access in the read step, one in the execute step for LDR, LDI, ST, STI and STR
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = tgt9[AW-1:0];
    mem_wdata = rb;
    if (ctrl.step_read) begin
      mem_en = 1'b1;
      case (func_r)
        FN_EXEC: begin
          mem_addr = tgt9[AW-1:0];
        end
        FN_WRITE: begin
          mem_we    = 1'b1;
          mem_addr  = maddr_r[AW-1:0];
          mem_wdata = mdata_r;
        end
        default: begin
          mem_addr = maddr_r[AW-1:0];
        end
      endcase
    end else if (ctrl.step_exec && is_exec && !illegal) begin
      unique case (op)
        OP_LDR: begin
          mem_en   = 1'b1;
          mem_addr = base6[AW-1:0];
        end
        OP_LDI: begin
          mem_en   = 1'b1;
          mem_addr = mem_q[AW-1:0];
        end
        OP_ST: begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = tgt9[AW-1:0];
        end
        OP_STI: begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = mem_q[AW-1:0];
        end
        OP_STR: begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = base6[AW-1:0];
        end
        default: begin
          mem_en = 1'b0;
        end
      endcase
    end
  end

  lc3ie_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_word_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_q)
  );

  // execute step: ALU result and next PC
  always_comb begin
    res_nxt = mem_q;
    npc_nxt = pc_r;
    if (is_exec && !illegal) begin
      npc_nxt = pc_inc;
      unique case (op)
        OP_ADD: res_nxt = ra + opb;
        OP_AND: res_nxt = ra & opb;
        OP_NOT: res_nxt = ~ra;
        OP_LEA: res_nxt = tgt9;
        OP_BR: begin
          if ((dr & flags_r) != 3'b000) begin
            npc_nxt = tgt9;
          end
        end
        OP_JMP: npc_nxt = ra;
        OP_JSR: begin
          res_nxt = pc_inc;
          npc_nxt = ins_r[11] ? tgt11 : ra;
        end
        default: res_nxt = mem_q;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_exec) begin
      res_r <= res_nxt;
      npc_r <= npc_nxt;
    end
  end

  // commit step: register write value and flags
  always_comb begin
    wr_w = 1'b0;
    if (is_exec && !illegal) begin
      case (op) inside
        OP_ADD, OP_AND, OP_NOT, OP_JSR, OP_LD, OP_LDI, OP_LDR, OP_LEA: wr_w = 1'b1;
        default: wr_w = 1'b0;
      endcase
    end
  end

  // memory read data is held through commit since the port is idle
  assign dval_w    = ((op == OP_LDI) || (op == OP_LDR)) ? mem_q : res_r;
  assign didx_w    = (op == OP_JSR) ? LINK_REG : dr;
  assign flags_nxt = (wr_w && (op != OP_JSR)) ? flags_of(dval_w) : flags_r;
  assign rf_we     = ctrl.commit && wr_w;

  // PC and condition codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= START_PC_RESET;
      flags_r <= FLAGS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pc_r <= cfg_data;
    end else if (ctrl.commit) begin
      pc_r    <= npc_r;
      flags_r <= flags_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_pc_after_r    <= npc_r;
      out_cond_codes_r  <= flags_nxt;
      out_dest_index_r  <= wr_w ? didx_w : 3'd0;
      out_dest_value_r  <= wr_w ? dval_w : 16'h0000;
      out_reg_written_r <= wr_w;
      out_read_data_r   <= func_r[1] ? res_r : 16'h0000;
      out_illegal_op_r  <= illegal;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pc_after    = out_pc_after_r;
  assign out_cond_codes  = out_cond_codes_r;
  assign out_dest_index  = out_dest_index_r;
  assign out_dest_value  = out_dest_value_r;
  assign out_reg_written = out_reg_written_r;
  assign out_read_data   = out_read_data_r;
  assign out_illegal_op  = out_illegal_op_r;

  // checks
  `LC3IE_ASSERT_ALWAYS(a_flags_onehot, clk, rst_n, $onehot(flags_r), "condition codes not one-hot")
  `LC3IE_ASSERT_ALWAYS(a_one_step, clk, rst_n, $onehot0({ctrl.step_read, ctrl.step_exec, ctrl.commit}), "sequencer steps overlap")
  `LC3IE_ASSERT_ALWAYS(a_no_dual_write, clk, rst_n, !(mem_we && rf_we), "memory and register write in one cycle")
  `LC3IE_ASSERT_NEXT(a_illegal_keeps_pc, clk, rst_n, ctrl.commit && illegal && !cfg_valid, pc_r == $past(pc_r), "illegal opcode changed the PC")

endmodule

`default_nettype wire
